// ===== src/ssla_pkg.sv =====
// Package for the synchronous serial link: register indexes, codes and reset values.
`default_nettype none
package ssla_pkg;

  localparam int BYTE_BITS     = 8;
  localparam int COUNTER_WIDTH = 16;
  localparam int CFG_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int VALUE_W       = 7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIT_PHASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAP_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE    = 2'd3;

  // register reset values
  localparam logic [CFG_W-1:0]     RST_BIT_PHASE   = 16'd1;
  localparam logic [CFG_W-1:0]     RST_GAP_LIMIT   = 16'd50;
  localparam logic [CFG_W-1:0]     RST_ACK_TIMEOUT = 16'd1000;
  localparam logic [BYTE_BITS-1:0] RST_ACK_CODE    = 8'hAA;

  // transmitter occupancy codes
  localparam logic [1:0] TX_IDLE = 2'd0;
  localparam logic [1:0] TX_DATA = 2'd1;
  localparam logic [1:0] TX_ACK  = 2'd2;

  // transmit bit phases
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;

endpackage
`default_nettype wire

// ===== src/sync_serial_link_with_ack.sv =====
// Top level of the two-wire synchronous serial link with acknowledge handshake.
`default_nettype none
// One input beat is one timebase tick: the sampled rx clock and data lines plus an optional
// send request. Every accepted beat gives exactly one result beat, carrying the tx line levels
// for that tick, a received byte (bit 7 masked) when a non-ack byte completes, the outcome of a
// data send (acked or timed out) and ready_res, which says whether a request on the next tick
// will be taken. A beat is accepted every cycle while the result stage is drained: all of a
// tick's work sits between the link state registers and one result register, so throughput is
// one tick per clock, and each result shows in the cycle after its tick. in_stall is high
// only while a result is held by out_stall. Bytes go LSB first; each sent bit spends
// bit_phase_ticks in each of its three phases (data with clock low, clock high, clock low).
// Tick counters are COUNTER_WIDTH bits and saturate; register values above the counter
// maximum act as that maximum. Configuration is taken every cycle (cfg_ready tied high)
// and must only be written while the link is idle.
module sync_serial_link_with_ack #(
  parameter int COUNTER_WIDTH = ssla_pkg::COUNTER_WIDTH
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // tick input channel
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                in_rx_clock,
  input  wire                                in_rx_data,
  input  wire                                in_send_request,
  input  wire  [ssla_pkg::VALUE_W-1:0]       in_send_value,
  // result channel
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               out_tx_clock,
  output logic                               out_tx_data,
  output logic                               out_rx_valid,
  output logic [ssla_pkg::VALUE_W-1:0]       out_rx_value,
  output logic                               out_send_done,
  output logic                               out_send_acked,
  output logic                               out_ready_res,
  // configuration write channel
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [ssla_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [ssla_pkg::CFG_W-1:0]         cfg_data
);

  localparam int CW      = COUNTER_WIDTH;
  localparam int CMP_W   = (CW > ssla_pkg::CFG_W) ? CW : ssla_pkg::CFG_W;
  localparam int BB      = ssla_pkg::BYTE_BITS;
  localparam int BIDX_W  = $clog2(BB);
  localparam logic [CW-1:0]     CNT_MAX  = {CW{1'b1}};
  localparam logic [BIDX_W-1:0] LAST_BIT = BIDX_W'(BB - 1);

  // saturating tick counter increment
  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  // register value limited to the counter range, widened for compare
  function automatic logic [CMP_W-1:0] lim(input logic [ssla_pkg::CFG_W-1:0] v);
    lim = (CMP_W'(v) > CMP_W'(CNT_MAX)) ? CMP_W'(CNT_MAX) : CMP_W'(v);
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [ssla_pkg::CFG_W-1:0] bit_phase_r, gap_limit_r, ack_timeout_r;
  logic [BB-1:0]              ack_code_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_phase_r   <= ssla_pkg::RST_BIT_PHASE;
      gap_limit_r   <= ssla_pkg::RST_GAP_LIMIT;
      ack_timeout_r <= ssla_pkg::RST_ACK_TIMEOUT;
      ack_code_r    <= ssla_pkg::RST_ACK_CODE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssla_pkg::REG_BIT_PHASE:   bit_phase_r   <= cfg_data;
        ssla_pkg::REG_GAP_LIMIT:   gap_limit_r   <= cfg_data;
        ssla_pkg::REG_ACK_TIMEOUT: ack_timeout_r <= cfg_data;
        ssla_pkg::REG_ACK_CODE:    ack_code_r    <= cfg_data[BB-1:0];
        default:                   ack_code_r    <= ack_code_r;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // link state
  // ---------------------------------------------------------------------------
  logic              last_clk_r,  last_clk_nxt;
  logic [BB-1:0]     rx_shift_r,  rx_shift_nxt;
  logic [BIDX_W-1:0] rx_cnt_r,    rx_cnt_nxt;
  logic [CW-1:0]     gap_cnt_r,   gap_cnt_nxt;
  logic              ack_seen_r,  ack_seen_nxt;
  logic              ack_pend_r,  ack_pend_nxt;
  logic [BB-1:0]     tx_shift_r,  tx_shift_nxt;
  logic [BIDX_W-1:0] tx_bit_r,    tx_bit_nxt;
  logic [1:0]        tx_phase_r,  tx_phase_nxt;
  logic [CW-1:0]     phase_cnt_r, phase_cnt_nxt;
  logic [1:0]        tx_busy_r,   tx_busy_nxt;
  logic              awaiting_r,  awaiting_nxt;
  logic [CW-1:0]     wait_cnt_r,  wait_cnt_nxt;

  // tick results
  logic                          o_clk, o_dat, o_rxv, o_done, o_acked, o_ready;
  logic [ssla_pkg::VALUE_W-1:0]  o_rxval;
  logic                          ready_now, rx_edge;

  logic acc;
  assign acc       = in_valid && !in_stall;
  assign ready_now = (tx_busy_r == ssla_pkg::TX_IDLE) && !awaiting_r && !ack_pend_r;
  assign rx_edge   = in_rx_clock && !last_clk_r;

  always_comb begin
    last_clk_nxt  = in_rx_clock;
    rx_shift_nxt  = rx_shift_r;
    rx_cnt_nxt    = rx_cnt_r;
    ack_seen_nxt  = ack_seen_r;
    ack_pend_nxt  = ack_pend_r;
    tx_shift_nxt  = tx_shift_r;
    tx_bit_nxt    = tx_bit_r;
    tx_phase_nxt  = tx_phase_r;
    phase_cnt_nxt = phase_cnt_r;
    tx_busy_nxt   = tx_busy_r;
    awaiting_nxt  = awaiting_r;
    wait_cnt_nxt  = wait_cnt_r;
    o_clk   = 1'b0;
    o_dat   = 1'b0;
    o_rxv   = 1'b0;
    o_rxval = '0;
    o_done  = 1'b0;
    o_acked = 1'b0;

    // receiver: sample data on rising rx clock, drop a stale partial byte
    gap_cnt_nxt = sat_inc(gap_cnt_r);
    if (rx_edge) begin
      if (CMP_W'(gap_cnt_nxt) > CMP_W'(gap_limit_r)) begin
        rx_cnt_nxt   = '0;
        rx_shift_nxt = '0;
      end
      gap_cnt_nxt              = '0;
      rx_shift_nxt[rx_cnt_nxt] = in_rx_data;
      if (rx_cnt_nxt == LAST_BIT) begin
        rx_cnt_nxt = '0;
        if (rx_shift_nxt == ack_code_r) begin
          ack_seen_nxt = 1'b1;
        end else begin
          o_rxv        = 1'b1;
          o_rxval      = rx_shift_nxt[ssla_pkg::VALUE_W-1:0];
          ack_pend_nxt = 1'b1;
        end
      end else begin
        rx_cnt_nxt = rx_cnt_nxt + 1'b1;
      end
    end

    // ack wait: an ack seen this tick already counts
    if (awaiting_r) begin
      if (ack_seen_nxt) begin
        o_done       = 1'b1;
        o_acked      = 1'b1;
        awaiting_nxt = 1'b0;
      end else begin
        wait_cnt_nxt = sat_inc(wait_cnt_r);
        if (CMP_W'(wait_cnt_nxt) >= lim(ack_timeout_r)) begin
          o_done       = 1'b1;
          awaiting_nxt = 1'b0;
        end
      end
    end

    // transmitter start: a taken request beats a queued ack reply
    if (tx_busy_r == ssla_pkg::TX_IDLE) begin
      priority if (in_send_request && ready_now) begin
        tx_shift_nxt  = {1'b1, in_send_value};
        ack_seen_nxt  = 1'b0;
        tx_busy_nxt   = ssla_pkg::TX_DATA;
        tx_bit_nxt    = '0;
        tx_phase_nxt  = ssla_pkg::PH_SETUP;
        phase_cnt_nxt = '0;
      end else if (ack_pend_nxt) begin
        tx_shift_nxt  = ack_code_r;
        ack_pend_nxt  = 1'b0;
        tx_busy_nxt   = ssla_pkg::TX_ACK;
        tx_bit_nxt    = '0;
        tx_phase_nxt  = ssla_pkg::PH_SETUP;
        phase_cnt_nxt = '0;
      end else begin
        tx_busy_nxt = ssla_pkg::TX_IDLE;
      end
    end

    // transmitter drive and phase advance
    if (tx_busy_nxt != ssla_pkg::TX_IDLE) begin
      o_dat         = tx_shift_nxt[tx_bit_nxt];
      o_clk         = (tx_phase_nxt == ssla_pkg::PH_HIGH);
      phase_cnt_nxt = sat_inc(phase_cnt_nxt);
      if (CMP_W'(phase_cnt_nxt) >= lim(bit_phase_r)) begin
        phase_cnt_nxt = '0;
        if (tx_phase_nxt >= ssla_pkg::PH_LOW) begin
          tx_phase_nxt = ssla_pkg::PH_SETUP;
          if (tx_bit_nxt == LAST_BIT) begin
            if (tx_busy_nxt == ssla_pkg::TX_DATA) begin
              awaiting_nxt = 1'b1;
              wait_cnt_nxt = '0;
            end
            tx_busy_nxt = ssla_pkg::TX_IDLE;
            tx_bit_nxt  = '0;
          end else begin
            tx_bit_nxt = tx_bit_nxt + 1'b1;
          end
        end else begin
          tx_phase_nxt = tx_phase_nxt + 1'b1;
        end
      end
    end

    o_ready = (tx_busy_nxt == ssla_pkg::TX_IDLE) && !awaiting_nxt && !ack_pend_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_clk_r  <= 1'b0;
      rx_shift_r  <= '0;
      rx_cnt_r    <= '0;
      gap_cnt_r   <= CNT_MAX;
      ack_seen_r  <= 1'b0;
      ack_pend_r  <= 1'b0;
      tx_shift_r  <= '0;
      tx_bit_r    <= '0;
      tx_phase_r  <= ssla_pkg::PH_SETUP;
      phase_cnt_r <= '0;
      tx_busy_r   <= ssla_pkg::TX_IDLE;
      awaiting_r  <= 1'b0;
      wait_cnt_r  <= '0;
    end else if (acc) begin
      last_clk_r  <= last_clk_nxt;
      rx_shift_r  <= rx_shift_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      gap_cnt_r   <= gap_cnt_nxt;
      ack_seen_r  <= ack_seen_nxt;
      ack_pend_r  <= ack_pend_nxt;
      tx_shift_r  <= tx_shift_nxt;
      tx_bit_r    <= tx_bit_nxt;
      tx_phase_r  <= tx_phase_nxt;
      phase_cnt_r <= phase_cnt_nxt;
      tx_busy_r   <= tx_busy_nxt;
      awaiting_r  <= awaiting_nxt;
      wait_cnt_r  <= wait_cnt_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // result register; input stalls only while a result is held
  // ---------------------------------------------------------------------------
  logic out_valid_r;

  assign in_stall  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_tx_clock   <= o_clk;
      out_tx_data    <= o_dat;
      out_rx_valid   <= o_rxv;
      out_rx_value   <= o_rxval;
      out_send_done  <= o_done;
      out_send_acked <= o_acked;
      out_ready_res  <= o_ready;
    end
  end

`ifndef SYNTHESIS
  // every taken tick leaves a result behind it
  a_tick_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid_r)
    else $error("accepted tick produced no result");

  // a data byte is never on the wire while its own ack wait runs
  a_no_send_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    !(awaiting_r && (tx_busy_r == ssla_pkg::TX_DATA)))
    else $error("data send overlaps ack wait");

  // ack outcome only alongside a finished send
  a_acked_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_send_acked) |-> out_send_done)
    else $error("send_acked without send_done");

  // a send can only finish while a wait was running
  a_done_from_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && o_done) |-> awaiting_r)
    else $error("send_done without a pending ack wait");
`endif

endmodule
`default_nettype wire
